// ----- rtl/char_lcd_nibble_write_sequencer_assert.svh -----
// Assertion macros for the LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CLNWS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("clnws assertion failed");

`define CLNWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clnws assertion failed");

`else

`define CLNWS_ASSERT_IMPL(label, ante, cons)

`define CLNWS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/clnws_pkg.sv -----
package clnws_pkg;

   localparam int TICK_W   = 24;
   localparam int ACTION_W = 2;
   localparam int PIN_W    = 8;
   localparam int STEP_W   = 4;
   localparam int CSR_IDX_W = 3;

   typedef logic [TICK_W-1:0] tick_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETUP,
      PH_PULSE,
      PH_HOLD,
      PH_WAIT
   } phase_type;

   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SETUP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_WAIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_WAIT = 3'd4;

   localparam tick_type SETUP_RESET       = 24'd1000;
   localparam tick_type PULSE_RESET       = 24'd10000;
   localparam tick_type HOLD_RESET        = 24'd1000;
   localparam tick_type FIRST_WAIT_RESET  = 24'd4000;
   localparam tick_type SECOND_WAIT_RESET = 24'd110;

   localparam logic [PIN_W-1:0] EN_PIN = 8'h01;
   localparam logic [PIN_W-1:0] RS_PIN = 8'h02;

   localparam logic [STEP_W-1:0] INIT_ITEMS      = 4'd8;
   localparam logic [STEP_W-1:0] INIT_FIRST_BYTE = 4'd4;

   // power-up sequence: four single nibbles, then four full bytes
   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         3'd0: b = 8'h03;
         3'd1: b = 8'h03;
         3'd2: b = 8'h03;
         3'd3: b = 8'h02;
         3'd4: b = 8'h28;
         3'd5: b = 8'h08;
         3'd6: b = 8'h01;
         3'd7: b = 8'h06;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [PIN_W-1:0] nibble_pins(input logic [3:0] nib, input logic rs);
      return {nib, 2'b00, rs, 1'b0};
   endfunction

endpackage

// ----- rtl/clnws_if.sv -----
interface clnws_req_if import clnws_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [7:0]          byte_value;
   logic                register_select;

   modport source (output valid, action, byte_value, register_select, input ready);
   modport sink   (input valid, action, byte_value, register_select, output ready);
endinterface

interface clnws_rsp_if import clnws_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [PIN_W-1:0] pin_byte;
   logic             busy_res;
   logic             done_res;
   logic             rejected;

   modport source (output valid, pin_byte, busy_res, done_res, rejected, input ready);
   modport sink   (input valid, pin_byte, busy_res, done_res, rejected, output ready);
endinterface

interface clnws_csr_if import clnws_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   tick_type             data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/char_lcd_nibble_write_sequencer.sv -----
// Channel   Dir   Payload                                        Handshake
// req_ch    in    action, byte_value, register_select            valid/ready
// rsp_ch    out   pin_byte, busy_res, done_res, rejected         valid/ready
// csr_ch    in    index (3b), data (24b)                         valid/ready, ready tied high
//
// One request beat per clock while rsp_ch takes its beats; each response beat is registered
// and shows in the next cycle. req_ch.ready is high while the response register is empty or being drained.
// Synchronous reset restores idle state and the default tick counts.
// A stalled rsp_ch holds its beat and blocks req_ch; sequencer state moves only on an
// accepted request beat.

`include "char_lcd_nibble_write_sequencer_assert.svh"

module char_lcd_nibble_write_sequencer import clnws_pkg::*; (
   input logic        clock,
   input logic        reset,
   clnws_req_if.sink  req_ch,
   clnws_rsp_if.source rsp_ch,
   clnws_csr_if.sink  csr_ch
);

   tick_type setup_ff, pulse_ff, hold_ff, first_wait_ff, second_wait_ff;

   phase_type         phase_ff, phase_in;
   tick_type          tick_ff, tick_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pending_ff, pending_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   logic              held_sel_ff, held_sel_in;
   logic [PIN_W-1:0]  pin_ff, pin_in;
   logic              init_act_ff, init_act_in;

   logic              rsp_valid_ff;
   logic [PIN_W-1:0]  rsp_pin_ff, rsp_pin_in;
   logic              rsp_busy_ff, rsp_busy_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_rej_ff, rsp_rej_in;

   logic              req_accept;
   logic              done_now, rej_now;
   tick_type          stage_len;
   logic              stage_end;
   logic [STEP_W-1:0] step_next, load_step;
   logic [7:0]        load_byte;
   logic              load_split;
   logic [PIN_W-1:0]  load_pin;
   logic              adv_done;
   logic              need_wait;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      case (phase_ff)
         PH_SETUP: stage_len = setup_ff;
         PH_PULSE: stage_len = pulse_ff;
         PH_HOLD:  stage_len = hold_ff;
         PH_WAIT:  stage_len = (step_ff == '0) ? first_wait_ff : second_wait_ff;
         default:  stage_len = '0;
      endcase
   end

   assign stage_end = !(({1'b0, tick_ff} + 25'd1) < {1'b0, stage_len});

   assign step_next  = step_ff + 4'd1;
   assign adv_done   = step_next >= INIT_ITEMS;
   assign load_step  = (req_ch.action == ACT_INIT) ? '0 : step_next;
   assign load_byte  = init_byte(load_step[2:0]);
   assign load_split = load_step >= INIT_FIRST_BYTE;
   assign load_pin   = nibble_pins(load_split ? load_byte[7:4] : load_byte[3:0], 1'b0);
   assign need_wait  = ((step_ff == 4'd0) && (first_wait_ff != '0)) ||
                       ((step_ff == 4'd1) && (second_wait_ff != '0));

   // next state
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      step_in      = step_ff;
      pending_in   = pending_ff;
      held_byte_in = held_byte_ff;
      held_sel_in  = held_sel_ff;
      pin_in       = pin_ff;
      init_act_in  = init_act_ff;
      done_now     = 1'b0;
      rej_now      = 1'b0;
      if (req_accept) begin
         case (req_ch.action)
            ACT_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (!stage_end) begin
                     tick_in = tick_ff + 24'd1;
                  end else begin
                     tick_in = '0;
                     case (phase_ff)
                        PH_SETUP: begin
                           pin_in   = pin_ff | EN_PIN;
                           phase_in = PH_PULSE;
                        end
                        PH_PULSE: begin
                           pin_in   = pin_ff & ~EN_PIN;
                           phase_in = PH_HOLD;
                        end
                        default: begin
                           if (phase_ff == PH_HOLD && pending_ff) begin
                              pending_in = 1'b0;
                              pin_in     = nibble_pins(held_byte_ff[3:0], held_sel_ff);
                              phase_in   = PH_SETUP;
                           end else if (phase_ff == PH_HOLD && !init_act_ff) begin
                              phase_in = PH_IDLE;
                              done_now = 1'b1;
                           end else if (phase_ff == PH_HOLD && need_wait) begin
                              phase_in = PH_WAIT;
                           end else begin
                              // advance the power-up sequence
                              step_in = step_next;
                              if (adv_done) begin
                                 init_act_in = 1'b0;
                                 phase_in    = PH_IDLE;
                                 done_now    = 1'b1;
                              end else begin
                                 held_byte_in = load_byte;
                                 held_sel_in  = 1'b0;
                                 pending_in   = load_split;
                                 pin_in       = load_pin;
                                 phase_in     = PH_SETUP;
                              end
                           end
                        end
                     endcase
                  end
               end
            end
            ACT_WRITE: begin
               if (phase_ff != PH_IDLE) begin
                  rej_now = 1'b1;
               end else begin
                  held_byte_in = req_ch.byte_value;
                  held_sel_in  = req_ch.register_select;
                  init_act_in  = 1'b0;
                  pending_in   = 1'b1;
                  pin_in       = nibble_pins(req_ch.byte_value[7:4], req_ch.register_select);
                  phase_in     = PH_SETUP;
                  tick_in      = '0;
               end
            end
            ACT_INIT: begin
               if (phase_ff != PH_IDLE) begin
                  rej_now = 1'b1;
               end else begin
                  init_act_in  = 1'b1;
                  step_in      = '0;
                  held_byte_in = load_byte;
                  held_sel_in  = 1'b0;
                  pending_in   = load_split;
                  pin_in       = load_pin;
                  phase_in     = PH_SETUP;
                  tick_in      = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response beat
   always_comb begin
      rsp_pin_in  = pin_in;
      rsp_busy_in = phase_in != PH_IDLE;
      rsp_done_in = done_now;
      rsp_rej_in  = rej_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff       <= SETUP_RESET;
         pulse_ff       <= PULSE_RESET;
         hold_ff        <= HOLD_RESET;
         first_wait_ff  <= FIRST_WAIT_RESET;
         second_wait_ff <= SECOND_WAIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SETUP:       setup_ff       <= csr_ch.data;
            REG_PULSE:       pulse_ff       <= csr_ch.data;
            REG_HOLD:        hold_ff        <= csr_ch.data;
            REG_FIRST_WAIT:  first_wait_ff  <= csr_ch.data;
            REG_SECOND_WAIT: second_wait_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         step_ff      <= '0;
         pending_ff   <= 1'b0;
         held_byte_ff <= '0;
         held_sel_ff  <= 1'b0;
         pin_ff       <= '0;
         init_act_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         step_ff      <= step_in;
         pending_ff   <= pending_in;
         held_byte_ff <= held_byte_in;
         held_sel_ff  <= held_sel_in;
         pin_ff       <= pin_in;
         init_act_ff  <= init_act_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_pin_ff  <= rsp_pin_in;
         rsp_busy_ff <= rsp_busy_in;
         rsp_done_ff <= rsp_done_in;
         rsp_rej_ff  <= rsp_rej_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.pin_byte = rsp_pin_ff;
   assign rsp_ch.busy_res = rsp_busy_ff;
   assign rsp_ch.done_res = rsp_done_ff;
   assign rsp_ch.rejected = rsp_rej_ff;

   `CLNWS_ASSERT_IMPL(a_en_only_in_pulse, pin_ff[0], phase_ff == PH_PULSE)
   `CLNWS_ASSERT_IMPL(a_pending_not_idle, pending_ff, phase_ff != PH_IDLE)
   `CLNWS_ASSERT_IMPL(a_wait_in_init, phase_ff == PH_WAIT, init_act_ff && (step_ff < 4'd2))
   `CLNWS_ASSERT_IMPL(a_reject_while_busy, rsp_valid_ff && rsp_rej_ff, rsp_busy_ff)
   `CLNWS_ASSERT_NEXT(a_done_goes_idle, req_accept && done_now, phase_ff == PH_IDLE)

endmodule

// ----- tb/char_lcd_pin_sequence_check.sv -----
module char_lcd_pin_sequence_check import clnws_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   clnws_req_if        req_ch,
   clnws_rsp_if        rsp_ch,
   clnws_csr_if        csr_ch,
   output int          fail_count,
   output int          outstanding,
   output logic        seq_busy
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIN_W-1:0] pin_byte;
      logic             busy;
      logic             done;
      logic             rejected;
   } lcd_beat_type;

   // power-up order: four lone nibbles, then four full bytes
   localparam logic [0:7][7:0] POWER_UP_SEQ = {
      8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06
   };

   tick_type         len_setup, len_pulse, len_hold, len_first, len_second;
   phase_type        phase;
   tick_type         tick_cnt;
   logic [STEP_W-1:0] init_idx;
   logic             low_due, held_rs, init_run;
   logic [7:0]       held_byte;
   logic [PIN_W-1:0] pins;
   lcd_beat_type     lcd_beats_due[$];
   int               errors = 0;

   function automatic void load_nibble(input logic [3:0] nib);
      pins = {nib, 4'b0000} | (held_rs ? RS_PIN : '0);
      phase = PH_SETUP;
      tick_cnt = '0;
   endfunction

   function automatic void load_power_up_entry();
      held_byte = POWER_UP_SEQ[init_idx[2:0]];
      held_rs = 1'b0;
      if (init_idx >= INIT_FIRST_BYTE) begin
         low_due = 1'b1;
         load_nibble(held_byte[7:4]);
      end else begin
         low_due = 1'b0;
         load_nibble(held_byte[3:0]);
      end
   endfunction

   function automatic logic next_power_up_entry();
      init_idx = init_idx + 4'd1;
      if (init_idx >= INIT_ITEMS) begin
         init_run = 1'b0;
         phase = PH_IDLE;
         tick_cnt = '0;
         return 1'b1;
      end
      load_power_up_entry();
      return 1'b0;
   endfunction

   function automatic logic finish_hold();
      if (low_due) begin
         low_due = 1'b0;
         load_nibble(held_byte[3:0]);
         return 1'b0;
      end
      if (init_run) begin
         if ((init_idx == 0 && len_first != 0) || (init_idx == 1 && len_second != 0)) begin
            phase = PH_WAIT;
            tick_cnt = '0;
            return 1'b0;
         end
         return next_power_up_entry();
      end
      phase = PH_IDLE;
      tick_cnt = '0;
      return 1'b1;
   endfunction

   function automatic logic count_tick();
      tick_type span;
      if (phase == PH_IDLE) return 1'b0;
      case (phase)
         PH_SETUP: span = len_setup;
         PH_PULSE: span = len_pulse;
         PH_HOLD:  span = len_hold;
         default:  span = (init_idx == 0) ? len_first : len_second;
      endcase
      if ({1'b0, tick_cnt} + 25'd1 < {1'b0, span}) begin
         tick_cnt = tick_cnt + 24'd1;
         return 1'b0;
      end
      tick_cnt = '0;
      if (phase == PH_SETUP) begin
         pins = pins | EN_PIN;
         phase = PH_PULSE;
         return 1'b0;
      end
      if (phase == PH_PULSE) begin
         pins = pins & ~EN_PIN;
         phase = PH_HOLD;
         return 1'b0;
      end
      if (phase == PH_HOLD) return finish_hold();
      return next_power_up_entry();
   endfunction

   function automatic lcd_beat_type predict_pins(input logic [ACTION_W-1:0] act,
                                                 input logic [7:0] value, input logic rs);
      lcd_beat_type b;
      logic         was_busy;
      b = '0;
      was_busy = (phase != PH_IDLE);
      if (act == ACT_TICK) begin
         b.done = count_tick();
      end else if (act == ACT_WRITE || act == ACT_INIT) begin
         if (was_busy) begin
            b.rejected = 1'b1;
         end else if (act == ACT_WRITE) begin
            held_byte = value;
            held_rs = rs;
            init_run = 1'b0;
            low_due = 1'b1;
            load_nibble(value[7:4]);
         end else begin
            init_run = 1'b1;
            init_idx = '0;
            load_power_up_entry();
         end
      end
      b.pin_byte = pins;
      b.busy = (phase != PH_IDLE);
      return b;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %02h, actual %02h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      lcd_beat_type want;
      if (reset) begin
         len_setup = SETUP_RESET;
         len_pulse = PULSE_RESET;
         len_hold = HOLD_RESET;
         len_first = FIRST_WAIT_RESET;
         len_second = SECOND_WAIT_RESET;
         phase = PH_IDLE;
         tick_cnt = '0;
         init_idx = '0;
         low_due = 1'b0;
         held_rs = 1'b0;
         init_run = 1'b0;
         held_byte = '0;
         pins = '0;
         lcd_beats_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_SETUP:       len_setup = csr_ch.data;
               REG_PULSE:       len_pulse = csr_ch.data;
               REG_HOLD:        len_hold = csr_ch.data;
               REG_FIRST_WAIT:  len_first = csr_ch.data;
               REG_SECOND_WAIT: len_second = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            lcd_beats_due.push_back(predict_pins(req_ch.action, req_ch.byte_value,
                                                 req_ch.register_select));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (lcd_beats_due.size() == 0) begin
               $error("rsp beat with no prediction waiting: pin_byte %02h", rsp_ch.pin_byte);
               errors++;
            end else begin
               want = lcd_beats_due.pop_front();
               check_field("pin_byte", want.pin_byte, rsp_ch.pin_byte);
               check_field("busy_res", 8'(want.busy), 8'(rsp_ch.busy_res));
               check_field("done_res", 8'(want.done), 8'(rsp_ch.done_res));
               check_field("rejected", 8'(want.rejected), 8'(rsp_ch.rejected));
            end
         end
      end
      fail_count <= errors;
      outstanding <= lcd_beats_due.size();
      seq_busy <= (phase != PH_IDLE);
   end

endmodule

// ----- tb/char_lcd_nibble_write_sequencer_test.sv -----
module char_lcd_nibble_write_sequencer_test import clnws_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
   localparam tick_type TICK_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, outstanding;
   logic seq_busy;
   bit   quiet = 1'b0;
   int   n_ticks = 0, n_writes = 0, n_inits = 0, n_none = 0, n_settings = 0;
   int   cfg_setup, cfg_pulse, cfg_hold, cfg_first, cfg_second;

   clnws_req_if req_if ();
   clnws_rsp_if rsp_if ();
   clnws_csr_if csr_if ();

   char_lcd_nibble_write_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   char_lcd_pin_sequence_check pin_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_ch      (csr_if),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .seq_busy    (seq_busy)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic int stage_len(input int v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic int nibble_ticks();
      return stage_len(cfg_setup) + stage_len(cfg_pulse) + stage_len(cfg_hold);
   endfunction

   task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [7:0] value,
                            input logic rs);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.byte_value <= value;
      req_if.register_select <= rs;
      do @(posedge clock); while (!req_if.ready);
      case (act)
         ACT_TICK:  n_ticks++;
         ACT_WRITE: n_writes++;
         ACT_INIT:  n_inits++;
         default:   n_none++;
      endcase
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(ACT_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_beat(ACT_WRITE, 8'($urandom), 1'($urandom));
         1: send_beat(ACT_INIT, 8'($urandom), 1'($urandom));
         default: send_beat(ACT_NONE, 8'($urandom), 1'($urandom));
      endcase
   endtask

   // drain every beat, then tick until the sequencer is back at rest
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      while (seq_busy) begin
         send_ticks(4);
         req_if.valid <= 1'b0;
         do @(posedge clock); while (outstanding != 0);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input tick_type value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic program_timing(input tick_type s, input tick_type p, input tick_type h,
                                 input tick_type f, input tick_type w);
      write_reg(REG_SETUP, s);
      write_reg(REG_PULSE, p);
      write_reg(REG_HOLD, h);
      write_reg(REG_FIRST_WAIT, f);
      write_reg(REG_SECOND_WAIT, w);
      // indexes past the last register must be dropped
      for (int k = 1; k <= 3; k++)
         write_reg(CSR_IDX_W'(int'(REG_SECOND_WAIT) + k),
                   $urandom_range(0, 1) ? TICK_MAX : tick_type'($urandom));
      csr_if.valid <= 1'b0;
      cfg_setup = int'(s);
      cfg_pulse = int'(p);
      cfg_hold = int'(h);
      cfg_first = int'(f);
      cfg_second = int'(w);
      n_settings++;
   endtask

   task automatic run_sequence(input logic [ACTION_W-1:0] act, input int full);
      int n;
      send_beat(act, 8'($urandom), 1'($urandom));
      n = full;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(0, full);
      repeat (n) begin
         if ($urandom_range(0, 24) == 0) send_noise();
         send_beat(ACT_TICK, 8'($urandom), 1'($urandom));
      end
   endtask

   function automatic int draw_stage();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r < 8) return $urandom_range(1, 4);
      return $urandom_range(5, 20);
   endfunction

   function automatic int draw_wait();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 0;
      if (r < 9) return $urandom_range(1, 6);
      return $urandom_range(7, 40);
   endfunction

   initial begin
      int target, phase_end, init_len, r;
      req_if.valid <= 1'b0;
      req_if.action <= ACT_TICK;
      req_if.byte_value <= '0;
      req_if.register_select <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= REG_SETUP;
      csr_if.data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // shortest timing, waits skipped; busy rejection and the unused code
      program_timing(1, 1, 1, 0, 0);
      send_beat(ACT_TICK, 8'h00, 1'b0);
      send_beat(ACT_NONE, 8'hFF, 1'b1);
      send_beat(ACT_WRITE, 8'hFF, 1'b1);
      send_beat(ACT_WRITE, 8'h00, 1'b0);
      send_beat(ACT_INIT, 8'hFF, 1'b1);
      send_beat(ACT_NONE, 8'h00, 1'b0);
      send_ticks(6);
      settle();

      // zero stage lengths count as one tick, waits at their top value
      program_timing(0, 0, 0, TICK_MAX, TICK_MAX);
      send_beat(ACT_WRITE, 8'h00, 1'b0);
      send_ticks(6);
      settle();

      // top stage lengths: only idle traffic under them
      program_timing(TICK_MAX, TICK_MAX, TICK_MAX, 1, 1);
      send_beat(ACT_TICK, 8'hA5, 1'b1);
      send_beat(ACT_NONE, 8'h5A, 1'b0);
      settle();

      target = n_ticks + n_writes + n_inits + 1400;
      while (n_ticks + n_writes + n_inits < target) begin
         program_timing(tick_type'(draw_stage()), tick_type'(draw_stage()),
                        tick_type'(draw_stage()), tick_type'(draw_wait()),
                        tick_type'(draw_wait()));
         quiet = ($urandom_range(0, 3) == 0);
         phase_end = n_ticks + n_writes + n_inits + 150;
         init_len = 12 * nibble_ticks() + cfg_first + cfg_second;
         while (n_ticks + n_writes + n_inits < phase_end &&
                n_ticks + n_writes + n_inits < target) begin
            r = $urandom_range(0, 99);
            if (r < 80 && (r < 60 || init_len > 250))
               run_sequence(ACT_WRITE, 2 * nibble_ticks());
            else if (r < 80)
               run_sequence(ACT_INIT, init_len);
            else
               repeat ($urandom_range(1, 3)) send_noise();
         end
         settle();
      end
      quiet = 1'b0;

      $display("Covered %0d ticks, %0d byte writes, %0d init requests, %0d unused-code beats",
               n_ticks, n_writes, n_inits, n_none);
      $display("across %0d timing settings, with a long response stall", n_settings);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      int hold, delivered;
      delivered = 0;
      rsp_if.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         // one long hold-off part way in, so the request side backs up
         hold = (delivered == 700) ? 90 : draw_gap();
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         delivered++;
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/clnws_pkg.sv
rtl/clnws_if.sv
rtl/char_lcd_nibble_write_sequencer.sv
tb/char_lcd_pin_sequence_check.sv
tb/char_lcd_nibble_write_sequencer_test.sv
